// File: design/bitmap_page_run_allocator_macros.svh
// ----------------------------------------------------------------------------
// bitmap page run allocator assertion macros
// implication checks on clk_i with rst_ni as disable
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_RUN_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BPRA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpra check failed");
`define BPRA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpra check failed");
`else
`define BPRA_ASSERT_IMP(lbl, ante, cons)
`define BPRA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/bpra_pkg.sv
// ----------------------------------------------------------------------------
// bpra_pkg
// shared types and constants of the bitmap page run allocator
// ----------------------------------------------------------------------------
`default_nettype none
package bpra_pkg;

  localparam int unsigned NUM_POOLS  = 4;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned CHUNK_BITS = 8;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned BASE_W     = 32;

  localparam logic [2:0] REG_KV_BASE  = 3'd0;
  localparam logic [2:0] REG_UV_BASE  = 3'd1;
  localparam logic [2:0] REG_KP_BASE  = 3'd2;
  localparam logic [2:0] REG_UP_BASE  = 3'd3;
  localparam logic [2:0] REG_KV_PAGES = 3'd4;
  localparam logic [2:0] REG_UV_PAGES = 3'd5;
  localparam logic [2:0] REG_KP_PAGES = 3'd6;
  localparam logic [2:0] REG_UP_PAGES = 3'd7;

  localparam logic [31:0] KV_BASE_RESET = 32'hC010_0000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MREAD,
    ST_MWRITE
  } state_e;

endpackage
`default_nettype wire

// File: design/bpra_ram.sv
// ----------------------------------------------------------------------------
// bpra_ram
// single port bitmap memory, one 32-bit word per access, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module bpra_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [31:0]   wdata_i,
  output logic      [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: design/bpra_ctrl.sv
// ----------------------------------------------------------------------------
// bpra_ctrl
// sequencer: clearing pass, first-fit scan 8 pages a cycle, run marking
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_page_run_allocator_macros.svh"
module bpra_ctrl #(
  parameter int unsigned POOL_PAGES = 4096,
  parameter int unsigned WW         = 7,
  parameter int unsigned AW         = 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [1:0]    pool_i,
  input  wire logic [12:0]   count_i,
  input  wire logic [31:0]   base_i [4],
  input  wire logic [12:0]   size_i [4],
  output logic               busy_o,
  output logic               done_o,
  output logic               ok_o,
  output logic      [31:0]   start_address_o,
  output logic               mem_en_o,
  output logic               mem_we_o,
  output logic      [AW-1:0] mem_addr_o,
  output logic      [31:0]   mem_wdata_o,
  input  wire logic [31:0]   mem_rdata_i
);

  localparam int unsigned LP = $clog2(POOL_PAGES);
  localparam int unsigned PW = LP + 1;
  localparam int unsigned CW = (PW > 13) ? PW : 13;

  bpra_pkg::state_e state_q, state_d;
  logic [1:0]    pool_q, pool_d;
  logic [PW-1:0] cnt_q, cnt_d, limit_q, limit_d, idx_q, idx_d, run_q, run_d;
  logic [LP-1:0] start_q, start_d, end_q, end_d;
  logic [WW-1:0] w_q, w_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          done_q, done_d, ok_q, ok_d;
  logic [31:0]   addr_q, addr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpra_pkg::ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pool_q  <= pool_d;
    cnt_q   <= cnt_d;
    limit_q <= limit_d;
    idx_q   <= idx_d;
    run_q   <= run_d;
    start_q <= start_d;
    end_q   <= end_d;
    w_q     <= w_d;
    ok_q    <= ok_d;
    addr_q  <= addr_d;
  end

  always_comb begin
    logic [CW-1:0] eff;
    logic [CW-1:0] lim;
    logic [7:0]    chunk;
    logic [PW-1:0] r;
    logic [PW-1:0] g;
    logic [PW-1:0] endg;
    logic          hit;
    logic          stop;
    logic [4:0]    lo;
    logic [4:0]    hi;
    logic [31:0]   mask;
    logic [LP-1:0] sidx;
    state_d = state_q;
    pool_d = pool_q;
    cnt_d = cnt_q;
    limit_d = limit_q;
    idx_d = idx_q;
    run_d = run_q;
    start_d = start_q;
    end_d = end_q;
    w_d = w_q;
    clr_d = clr_q;
    done_d = 1'b0;
    ok_d = ok_q;
    addr_d = addr_q;
    mem_en_o = 1'b0;
    mem_we_o = 1'b0;
    mem_addr_o = '0;
    mem_wdata_o = '0;
    eff = '0;
    lim = '0;
    chunk = '0;
    r = '0;
    g = '0;
    endg = '0;
    hit = 1'b0;
    stop = 1'b0;
    lo = '0;
    hi = '0;
    mask = '0;
    sidx = '0;
    unique case (state_q)
      bpra_pkg::ST_CLEAR: begin
        mem_en_o = 1'b1;
        mem_we_o = 1'b1;
        mem_addr_o = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(4 * (1 << WW) - 1)) begin
          state_d = bpra_pkg::ST_IDLE;
        end
      end
      bpra_pkg::ST_IDLE: begin
        if (start_i) begin
          eff = pool_i[1] ? CW'(1) : CW'(count_i);
          lim = (CW'(size_i[pool_i]) > CW'(POOL_PAGES)) ? CW'(POOL_PAGES)
                                                          : CW'(size_i[pool_i]);
          pool_d = pool_i;
          cnt_d = PW'(eff);
          limit_d = PW'(lim);
          idx_d = '0;
          run_d = '0;
          if (eff == '0 || eff > lim) begin
            done_d = 1'b1;
            ok_d = 1'b0;
            addr_d = '0;
          end else begin
            mem_en_o = 1'b1;
            mem_addr_o = {pool_i, WW'(0)};
            state_d = bpra_pkg::ST_SCAN;
          end
        end
      end
      bpra_pkg::ST_SCAN: begin
        chunk = 8'(mem_rdata_i >> {idx_q[4:3], 3'b000});
        r = run_q;
        for (int k = 0; k < 8; k++) begin
          g = idx_q + PW'(k);
          if (!hit && !stop) begin
            if (g >= limit_q) begin
              stop = 1'b1;
            end else if (chunk[k]) begin
              r = '0;
            end else begin
              r = r + 1'b1;
              if (r == cnt_q) begin
                hit = 1'b1;
                endg = g;
              end
            end
          end
        end
        if (hit) begin
          sidx = LP'(endg + 1'b1 - cnt_q);
          start_d = sidx;
          end_d = LP'(endg);
          w_d = WW'(sidx >> 5);
          state_d = bpra_pkg::ST_MREAD;
        end else if (stop) begin
          done_d = 1'b1;
          ok_d = 1'b0;
          addr_d = '0;
          state_d = bpra_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + PW'(bpra_pkg::CHUNK_BITS);
          run_d = r;
          if (idx_q[4:3] == 2'b11) begin
            mem_en_o = 1'b1;
            mem_addr_o = {pool_q, WW'((idx_q >> 5) + 1'b1)};
          end
        end
      end
      bpra_pkg::ST_MREAD: begin
        mem_en_o = 1'b1;
        mem_addr_o = {pool_q, w_q};
        state_d = bpra_pkg::ST_MWRITE;
      end
      bpra_pkg::ST_MWRITE: begin
        lo = (w_q == WW'(start_q >> 5)) ? start_q[4:0] : 5'd0;
        hi = (w_q == WW'(end_q >> 5)) ? end_q[4:0] : 5'd31;
        for (int b = 0; b < 32; b++) begin
          mask[b] = (5'(b) >= lo) && (5'(b) <= hi);
        end
        mem_en_o = 1'b1;
        mem_we_o = 1'b1;
        mem_addr_o = {pool_q, w_q};
        mem_wdata_o = mem_rdata_i | mask;
        if (w_q == WW'(end_q >> 5)) begin
          done_d = 1'b1;
          ok_d = 1'b1;
          addr_d = base_i[pool_q] + (32'(start_q) << bpra_pkg::PAGE_SHIFT);
          state_d = bpra_pkg::ST_IDLE;
        end else begin
          w_d = w_q + 1'b1;
          state_d = bpra_pkg::ST_MREAD;
        end
      end
      default: begin
        state_d = bpra_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != bpra_pkg::ST_IDLE);
  assign done_o = done_q;
  assign ok_o = ok_q;
  assign start_address_o = addr_q;

  `BPRA_ASSERT_IMP(a_done_idle, done_q, !busy_o)
  `BPRA_ASSERT_IMP(a_fail_zero, done_q && !ok_q, addr_q == 32'd0)
  `BPRA_ASSERT_IMP(a_write_phase, mem_we_o, (state_q == bpra_pkg::ST_CLEAR) || (state_q == bpra_pkg::ST_MWRITE))
  `BPRA_ASSERT_NXT(a_scan_in_pool, state_q == bpra_pkg::ST_SCAN && !done_d, idx_q <= limit_q)

endmodule
`default_nettype wire

// File: design/bitmap_page_run_allocator.sv
// bitmap page run allocator: first-fit page runs over four bitmaps in one ram
// a request scans its pool bitmap first fit, then marks the run it found; pools 2 and 3
// (pool_i[1] set) always ask for a single page, whatever count_i says
// one request at a time, busy_o high meanwhile; marking is a read-modify-write per word
// the receiver cannot stall, done_o lasts one cycle
// reset: control state and apb registers to defaults, then a ram clearing pass
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator
// top level with apb register file, sequencer and bitmap ram
// ----------------------------------------------------------------------------
`default_nettype none
module bitmap_page_run_allocator #(
  parameter int unsigned POOL_PAGES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  pool_i,
  input  wire logic [12:0] count_i,
  output logic             done_o,
  output logic             ok_o,
  output logic      [31:0] start_address_o
);

  localparam int unsigned LP = $clog2(POOL_PAGES);
  localparam int unsigned WW = (LP > 5) ? LP - 5 : 1;
  localparam int unsigned AW = WW + 2;
  localparam int unsigned DEPTH = 4 * (1 << WW);

  logic [31:0] base_q [4];
  logic [12:0] size_q [4];
  logic [2:0]  ridx;
  logic        wr;
  logic        mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_wdata, mem_rdata;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q[0] <= bpra_pkg::KV_BASE_RESET;
      base_q[1] <= '0;
      base_q[2] <= '0;
      base_q[3] <= '0;
      size_q[0] <= '0;
      size_q[1] <= '0;
      size_q[2] <= '0;
      size_q[3] <= '0;
    end else if (wr) begin
      unique case (ridx)
        bpra_pkg::REG_KV_BASE:  base_q[0] <= pwdata;
        bpra_pkg::REG_UV_BASE:  base_q[1] <= pwdata;
        bpra_pkg::REG_KP_BASE:  base_q[2] <= pwdata;
        bpra_pkg::REG_UP_BASE:  base_q[3] <= pwdata;
        bpra_pkg::REG_KV_PAGES: size_q[0] <= pwdata[12:0];
        bpra_pkg::REG_UV_PAGES: size_q[1] <= pwdata[12:0];
        bpra_pkg::REG_KP_PAGES: size_q[2] <= pwdata[12:0];
        bpra_pkg::REG_UP_PAGES: size_q[3] <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      bpra_pkg::REG_KV_BASE:  prdata = base_q[0];
      bpra_pkg::REG_UV_BASE:  prdata = base_q[1];
      bpra_pkg::REG_KP_BASE:  prdata = base_q[2];
      bpra_pkg::REG_UP_BASE:  prdata = base_q[3];
      bpra_pkg::REG_KV_PAGES: prdata = 32'(size_q[0]);
      bpra_pkg::REG_UV_PAGES: prdata = 32'(size_q[1]);
      bpra_pkg::REG_KP_PAGES: prdata = 32'(size_q[2]);
      bpra_pkg::REG_UP_PAGES: prdata = 32'(size_q[3]);
      default:                prdata = '0;
    endcase
  end

  bpra_ctrl #(
    .POOL_PAGES(POOL_PAGES),
    .WW(WW),
    .AW(AW)
  ) u_ctrl (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .pool_i(pool_i),
    .count_i(count_i),
    .base_i(base_q),
    .size_i(size_q),
    .busy_o(busy_o),
    .done_o(done_o),
    .ok_o(ok_o),
    .start_address_o(start_address_o),
    .mem_en_o(mem_en),
    .mem_we_o(mem_we),
    .mem_addr_o(mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  bpra_ram #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_ram (
    .clk_i(clk_i),
    .en_i(mem_en),
    .we_i(mem_we),
    .addr_i(mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

endmodule
`default_nettype wire
